// ----- design/merkle_branch_sha256d_fold_assert.svh -----
// Assertion macros for the merkle branch fold block
`ifndef MERKLE_BRANCH_SHA256D_FOLD_ASSERT_SVH
`define MERKLE_BRANCH_SHA256D_FOLD_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MBF_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("merkle fold check failed");
// next-cycle implication
`define MBF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("merkle fold sequence check failed");
`endif

// ----- design/mbf_pkg.sv -----
// Types and constants shared by the merkle branch fold design
package mbf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    localparam logic [0:0] OP_COINBASE = 1'b0;
    localparam logic [0:0] OP_SIBLING  = 1'b1;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] k_round(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // byte reverse of a 32-bit word
    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- design/merkle_branch_sha256d_fold.sv -----
// Merkle branch fold: double SHA-256 of running root and sibling, one round per cycle
//
//  channel | direction | signals
//  in      | input     | i_valid, o_stall, i_op, i_hash_word, i_word_index, i_end_of_branch
//  out     | output    | o_valid, i_stall, o_root_word, o_root_word_index, o_last
//
// A coinbase word or a sibling word 0..2 is stored, followed by output if flagged.
// Word 3 of a sibling runs three compressions through one round unit, each a load,
// 64 rounds and a chaining add, before the next transaction is accepted.
// Reset clears the root, the sequencer and the output; buffers are not reset.
// A stalled output holds its word; the input stalls until all four words leave.
module merkle_branch_sha256d_fold (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [63:0] i_hash_word,
    input  logic [1:0]  i_word_index,
    input  logic        i_end_of_branch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_root_word,
    output logic [1:0]  o_root_word_index,
    output logic        o_last
);

    mbf_pkg::t_state r_state, n_state;
    logic [63:0]  r_root [4];
    logic [63:0]  r_sib  [4];
    logic [255:0] r_h;            // chaining value, a in [255:224]
    logic [255:0] r_v;            // working variables a..h
    logic [31:0]  r_w [16];       // schedule window, oldest in [0]
    logic [5:0]   r_rnd;
    logic [1:0]   r_pass;         // which compression of the fold
    logic         r_end;
    logic [1:0]   r_oidx;

    logic in_acc, out_acc, done_rnd;
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = o_valid && !i_stall;
    assign done_rnd = (r_rnd == 6'd63);

    // message block for the current pass
    logic [511:0] blk;
    always_comb begin
        blk = '0;
        case (r_pass)
            2'd0: begin
                for (int i = 0; i < 8; i++) begin
                    blk[511-32*i -: 32] = mbf_pkg::bswap32(r_root[i/2][32*(i%2) +: 32]);
                    blk[255-32*i -: 32] = mbf_pkg::bswap32(r_sib[i/2][32*(i%2) +: 32]);
                end
            end
            2'd1: begin
                blk[511:480] = 32'h80000000;
                blk[31:0]    = 32'd512;
            end
            default: begin
                blk[511:256] = r_h;
                blk[255:224] = 32'h80000000;
                blk[31:0]    = 32'd256;
            end
        endcase
    end

    // round datapath
    logic [31:0] a, b, c, d, e, f, g, h, w, s0, s1, t1, t2, ws0, ws1, wn;
    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        w   = r_w[0];
        s1  = mbf_pkg::rotr(e, 6) ^ mbf_pkg::rotr(e, 11) ^ mbf_pkg::rotr(e, 25);
        t1  = h + s1 + ((e & f) ^ (~e & g)) + mbf_pkg::k_round(r_rnd) + w;
        s0  = mbf_pkg::rotr(a, 2) ^ mbf_pkg::rotr(a, 13) ^ mbf_pkg::rotr(a, 22);
        t2  = s0 + ((a & b) ^ (a & c) ^ (b & c));
        ws0 = mbf_pkg::rotr(r_w[1], 7) ^ mbf_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        ws1 = mbf_pkg::rotr(r_w[14], 17) ^ mbf_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wn  = r_w[0] + ws0 + r_w[9] + ws1;
    end

    // chaining add
    logic [255:0] hsum;
    always_comb begin
        for (int i = 0; i < 8; i++) hsum[32*i +: 32] = r_h[32*i +: 32] + r_v[32*i +: 32];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbf_pkg::ST_IDLE:
                if (in_acc) begin
                    if (i_op == mbf_pkg::OP_SIBLING && i_word_index == 2'd3)
                        n_state = mbf_pkg::ST_LOAD;
                    else if (i_end_of_branch)
                        n_state = mbf_pkg::ST_OUT;
                end
            mbf_pkg::ST_LOAD:  n_state = mbf_pkg::ST_ROUND;
            mbf_pkg::ST_ROUND: if (done_rnd) n_state = mbf_pkg::ST_ADD;
            mbf_pkg::ST_ADD:
                if (r_pass != 2'd2) n_state = mbf_pkg::ST_LOAD;
                else if (r_end)     n_state = mbf_pkg::ST_OUT;
                else                n_state = mbf_pkg::ST_IDLE;
            mbf_pkg::ST_OUT:
                if (out_acc && r_oidx == 2'd3) n_state = mbf_pkg::ST_IDLE;
            default: n_state = mbf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall           = (r_state != mbf_pkg::ST_IDLE);
        o_valid           = (r_state == mbf_pkg::ST_OUT);
        o_root_word       = r_root[r_oidx];
        o_root_word_index = r_oidx;
        o_last            = (r_oidx == 2'd3);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbf_pkg::ST_IDLE;
            r_rnd   <= '0;
            r_pass  <= '0;
            r_end   <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 4; i++) r_root[i] <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_end  <= i_end_of_branch;
                r_pass <= '0;
                r_oidx <= '0;
                if (i_op == mbf_pkg::OP_COINBASE) r_root[i_word_index] <= i_hash_word;
            end
            if (r_state == mbf_pkg::ST_LOAD) r_rnd <= '0;
            if (r_state == mbf_pkg::ST_ROUND) r_rnd <= r_rnd + 6'd1;
            if (r_state == mbf_pkg::ST_ADD) begin
                r_pass <= r_pass + 2'd1;
                if (r_pass == 2'd2) begin
                    for (int i = 0; i < 8; i++)
                        r_root[i/2][32*(i%2) +: 32] <=
                            mbf_pkg::bswap32(hsum[255-32*i -: 32]);
                end
            end
            if (out_acc) r_oidx <= r_oidx + 2'd1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == mbf_pkg::OP_SIBLING) r_sib[i_word_index] <= i_hash_word;
        case (r_state)
            mbf_pkg::ST_LOAD: begin
                if (r_pass != 2'd1) begin
                    r_h <= mbf_pkg::H_INIT;
                    r_v <= mbf_pkg::H_INIT;
                end else begin
                    r_v <= r_h;
                end
                for (int i = 0; i < 16; i++) r_w[i] <= blk[511-32*i -: 32];
            end
            mbf_pkg::ST_ROUND: begin
                r_v <= {t1 + t2, a, b, c, d + t1, e, f, g};
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= wn;
            end
            mbf_pkg::ST_ADD: r_h <= hsum;
            default: ;
        endcase
    end

`include "merkle_branch_sha256d_fold_assert.svh"
    `MBF_ASSERT_IMP(a_out_idle, i_clk, i_rst_n, o_valid, o_stall)
    `MBF_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid && o_last, o_root_word_index == 2'd3)
    `MBF_ASSERT_NEXT(a_round_step, i_clk, i_rst_n,
        r_state == mbf_pkg::ST_ROUND && !done_rnd, r_rnd == $past(r_rnd) + 6'd1)

endmodule
